### rtl/sof_pkg.sv
`default_nettype none
package sof_pkg;

  localparam int ELEM_BITS   = 8;
  localparam int MAX_PATTERN = 16;
  localparam int INDEX_BITS  = 16;
  localparam int COUNT_BITS  = 16;
  localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // result queue geometry
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] start_index;
    logic                  is_match;
    logic                  done_res;
    logic [COUNT_BITS-1:0] match_count;
    logic                  overflow;
  } result_t;

  // up to two results per text item, packed from slot 0
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage
`default_nettype wire

### rtl/sof_core.sv
`default_nettype none
module sof_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [sof_pkg::ELEM_BITS-1:0] in_value,
  input  wire logic                          in_last,
  input  wire logic                          first_only,
  input  wire logic                          q_room,
  output sof_pkg::push_t                     push
);

  // input register
  logic                          iv_r;
  logic [1:0]                    cmd_r;
  logic [sof_pkg::ELEM_BITS-1:0] val_r;
  logic                          last_r;

  // pattern kept newest-first: pat_r[k] is pattern element len-1-k
  logic [sof_pkg::ELEM_BITS-1:0] pat_r [sof_pkg::MAX_PATTERN];
  logic [sof_pkg::ELEM_BITS-1:0] win_r [sof_pkg::MAX_PATTERN];
  logic [sof_pkg::ELEM_BITS-1:0] win_nxt [sof_pkg::MAX_PATTERN];
  logic [sof_pkg::LEN_BITS-1:0]   len_r;
  logic [sof_pkg::INDEX_BITS-1:0] pos_r, pos_nxt;
  logic [sof_pkg::COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [sof_pkg::INDEX_BITS-1:0] first_r, first_nxt;
  logic                           sat_r, sat_nxt;

  logic                           adv;
  logic [sof_pkg::MAX_PATTERN-1:0] eq;
  logic                           win_full;
  logic                           hit;
  logic                           is_first;
  logic                           emit;
  logic [sof_pkg::INDEX_BITS-1:0] start;
  logic [sof_pkg::INDEX_BITS:0]   pos_inc;
  sof_pkg::result_t               mres, dres;

  assign adv      = iv_r && q_room;
  assign in_ready = !iv_r || q_room;

  // shifted window and per-position compare
  always_comb begin
    win_nxt[0] = val_r;
    for (int k = 1; k < sof_pkg::MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
    for (int k = 0; k < sof_pkg::MAX_PATTERN; k++) begin
      eq[k] = (sof_pkg::LEN_BITS'(k) >= len_r) || (win_nxt[k] == pat_r[k]);
    end
  end

  // index, hit and counters
  always_comb begin
    sat_nxt  = sat_r || (pos_r == sof_pkg::INDEX_MAX);
    pos_nxt  = sat_nxt ? pos_r : pos_r + 1'b1;
    pos_inc  = {1'b0, pos_r} + 1'b1;
    win_full = sat_nxt || (pos_inc >= (sof_pkg::INDEX_BITS + 1)'(len_r));
    hit      = (len_r != '0) && win_full && (&eq);
    start    = pos_r - sof_pkg::INDEX_BITS'(len_r - 1'b1);
    is_first = (cnt_r == '0);
    emit     = hit && (is_first || !first_only);
    cnt_nxt  = (hit && cnt_r != sof_pkg::COUNT_MAX) ? cnt_r + 1'b1 : cnt_r;
    first_nxt = (hit && is_first) ? start : first_r;
  end

  // build the result items
  always_comb begin
    mres.start_index = start;
    mres.is_match    = 1'b1;
    mres.done_res    = 1'b0;
    mres.match_count = cnt_nxt;
    mres.overflow    = sat_nxt;

    dres.start_index = (cnt_nxt != '0) ? first_nxt : '0;
    dres.is_match    = (cnt_nxt != '0);
    dres.done_res    = 1'b1;
    dres.match_count = cnt_nxt;
    dres.overflow    = sat_nxt;

    push.r0  = emit ? mres : dres;
    push.r1  = dres;
    push.num = 2'd0;
    if (adv && cmd_r == sof_pkg::CMD_TEXT) begin
      push.num = {1'b0, emit} + {1'b0, last_r};
    end
  end

  // payload registers: input item, pattern, window
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      val_r  <= in_value;
      last_r <= in_last;
    end
    if (adv) begin
      case (cmd_r)
        sof_pkg::CMD_LOAD: begin
          pat_r[0] <= val_r;
        end
        sof_pkg::CMD_APPEND: begin
          if (len_r < sof_pkg::LEN_BITS'(sof_pkg::MAX_PATTERN)) begin
            for (int k = 1; k < sof_pkg::MAX_PATTERN; k++) begin
              pat_r[k] <= pat_r[k-1];
            end
            pat_r[0] <= val_r;
          end
        end
        sof_pkg::CMD_TEXT: begin
          for (int k = 0; k < sof_pkg::MAX_PATTERN; k++) begin
            win_r[k] <= win_nxt[k];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r    <= 1'b0;
      len_r   <= '0;
      pos_r   <= '0;
      cnt_r   <= '0;
      first_r <= '0;
      sat_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        iv_r <= in_valid;
      end
      if (adv) begin
        case (cmd_r)
          sof_pkg::CMD_LOAD: begin
            len_r   <= sof_pkg::LEN_BITS'(1);
            pos_r   <= '0;
            cnt_r   <= '0;
            first_r <= '0;
            sat_r   <= 1'b0;
          end
          sof_pkg::CMD_APPEND: begin
            if (len_r < sof_pkg::LEN_BITS'(sof_pkg::MAX_PATTERN)) begin
              len_r <= len_r + 1'b1;
            end
            pos_r   <= '0;
            cnt_r   <= '0;
            first_r <= '0;
            sat_r   <= 1'b0;
          end
          sof_pkg::CMD_TEXT: begin
            if (last_r) begin
              pos_r   <= '0;
              cnt_r   <= '0;
              first_r <= '0;
              sat_r   <= 1'b0;
            end else begin
              pos_r   <= pos_nxt;
              cnt_r   <= cnt_nxt;
              first_r <= first_nxt;
              sat_r   <= sat_nxt;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### rtl/sof_outq.sv
`default_nettype none
module sof_outq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sof_pkg::push_t   push,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sof_pkg::result_t      out_res
);

  sof_pkg::result_t               mem_r [sof_pkg::QDEPTH];
  logic [sof_pkg::QPTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [sof_pkg::QCNT_BITS-1:0]  cnt_r;
  logic                           pop;
  logic [sof_pkg::QPTR_BITS-1:0]  wr_ptr1;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = mem_r[rd_ptr_r];
  assign wr_ptr1   = wr_ptr_r + 1'b1;
  // room for a full pair of results
  assign room      = (cnt_r <= sof_pkg::QCNT_BITS'(sof_pkg::QDEPTH - 2));

  // store pushed items
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr1] <= push.r1;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + sof_pkg::QPTR_BITS'(push.num);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + sof_pkg::QCNT_BITS'(push.num) - sof_pkg::QCNT_BITS'(pop);
    end
  end

endmodule
`default_nettype wire

### rtl/sequence_occurrence_finder_unit.sv
// An accepted item is held in the input register, then its results are written
//   into the result queue; both results of one item enter the queue together.
// Throughput: one item per cycle while the queue has room for two results, bounded
//   by the output port at one result per cycle; a four-entry queue decouples them.
// Reset (synchronous, rst_n low): clears pattern length, text position, count,
//   first match, saturation flag, first_only and the result queue.
`default_nettype none
module sequence_occurrence_finder_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_cmd,
  input  wire logic [sof_pkg::ELEM_BITS-1:0]   in_value,
  input  wire logic                            in_last,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [sof_pkg::INDEX_BITS-1:0]       out_start_index,
  output logic                                 out_is_match,
  output logic                                 out_done_res,
  output logic [sof_pkg::COUNT_BITS-1:0]       out_match_count,
  output logic                                 out_overflow,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic                            cfg_first_only
);

  logic             first_only_r;
  logic             q_room;
  sof_pkg::push_t   push;
  sof_pkg::result_t res;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_only_r <= 1'b0;
    end else if (cfg_valid) begin
      first_only_r <= cfg_first_only;
    end
  end

  sof_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_value   (in_value),
    .in_last    (in_last),
    .first_only (first_only_r),
    .q_room     (q_room),
    .push       (push)
  );

  sof_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_start_index = res.start_index;
  assign out_is_match    = res.is_match;
  assign out_done_res    = res.done_res;
  assign out_match_count = res.match_count;
  assign out_overflow    = res.overflow;

endmodule
`default_nettype wire

### rtl/sof_checker.sv
`default_nettype none
module sof_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [sof_pkg::INDEX_BITS-1:0]  out_start_index,
  input  wire logic                            out_is_match,
  input  wire logic                            out_done_res,
  input  wire logic [sof_pkg::COUNT_BITS-1:0]  out_match_count
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start_index) &&
      $stable(out_match_count) && $stable(out_done_res))
    else $error("stalled result item changed");

  // reset empties the result queue
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item pending after reset");

  // a match item always reports a hit and a nonzero count
  a_match_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_is_match && (out_match_count != '0))
    else $error("match item without hit");

  // a done item without hits carries zero count and zero start
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res && !out_is_match |->
      (out_match_count == '0) && (out_start_index == '0))
    else $error("done item without hits has stale fields");

endmodule

bind sequence_occurrence_finder_unit sof_checker u_sof_checker (.*);
`default_nettype wire

### verif/sof_occurrence_checker.sv
`timescale 1ns / 1ps
module sof_occurrence_checker
  import sof_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_cmd,
  input  logic [ELEM_BITS-1:0]  in_value,
  input  logic                  in_last,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [INDEX_BITS-1:0] out_start_index,
  input  logic                  out_is_match,
  input  logic                  out_done_res,
  input  logic [COUNT_BITS-1:0] out_match_count,
  input  logic                  out_overflow,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic                  cfg_first_only,
  output int                    mismatches,
  output int                    reports_due,
  output int                    matches_checked,
  output int                    texts_checked
);

  // shadow of the search state
  logic [ELEM_BITS-1:0]  motif [MAX_PATTERN];
  logic [LEN_BITS-1:0]   motif_len;
  logic [ELEM_BITS-1:0]  recent [MAX_PATTERN];
  logic [INDEX_BITS-1:0] text_pos;
  logic [COUNT_BITS-1:0] hit_count;
  logic [INDEX_BITS-1:0] first_hit;
  logic                  pos_pinned;
  logic                  only_first;

  result_t report_queue [$];
  int      errs = 0;
  int      hits_seen = 0;
  int      texts_seen = 0;

  task automatic restart_text();
    text_pos   = '0;
    hit_count  = '0;
    first_hit  = '0;
    pos_pinned = 1'b0;
  endtask

  function automatic result_t make_report(logic [INDEX_BITS-1:0] start, logic hit, logic fin);
    result_t r;
    r.start_index = start;
    r.is_match    = hit;
    r.done_res    = fin;
    r.match_count = hit_count;
    r.overflow    = pos_pinned;
    return r;
  endfunction

  // Work out the reports caused by one accepted item
  task automatic scan_element(logic [1:0] cmd, logic [ELEM_BITS-1:0] val, logic last);
    logic [INDEX_BITS-1:0] idx;
    logic [INDEX_BITS-1:0] start;
    logic                  hit;
    logic                  opening;
    int                    span;
    case (cmd)
      CMD_LOAD: begin
        motif[0]  = val;
        motif_len = LEN_BITS'(1);
        restart_text();
      end
      CMD_APPEND: begin
        if (motif_len < MAX_PATTERN) begin
          motif[motif_len] = val;
          motif_len        = motif_len + 1'b1;
        end
        restart_text();
      end
      CMD_TEXT: begin
        // shift the window: recent[k] is the element taken k steps ago
        for (int k = MAX_PATTERN - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = val;
        // pin the index once it reaches its maximum
        if (text_pos == INDEX_MAX) begin
          pos_pinned = 1'b1;
          idx        = INDEX_MAX;
        end else begin
          idx      = text_pos;
          text_pos = text_pos + 1'b1;
        end
        span = int'(motif_len);
        if (span > 0 && (pos_pinned || int'(idx) + 1 >= span)) begin
          hit = 1'b1;
          for (int j = 0; j < span; j++) begin
            if (motif[j] != recent[span-1-j]) hit = 1'b0;
          end
          if (hit) begin
            start   = idx - INDEX_BITS'(span - 1);
            opening = (hit_count == '0);
            if (opening) first_hit = start;
            if (hit_count != COUNT_MAX) hit_count = hit_count + 1'b1;
            if (opening || !only_first) report_queue.push_back(make_report(start, 1'b1, 1'b0));
          end
        end
        // close the text with its summary
        if (last) begin
          report_queue.push_back(make_report(hit_count != '0 ? first_hit : '0,
                                             hit_count != '0, 1'b1));
          restart_text();
        end
      end
      default: begin
        // unused command: drop it
      end
    endcase
  endtask

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      motif_len  = '0;
      only_first = 1'b0;
      restart_text();
      report_queue.delete();
      for (int k = 0; k < MAX_PATTERN; k++) begin
        motif[k]  = '0;
        recent[k] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) only_first = cfg_first_only;
      // check each result against the oldest waiting report
      if (out_valid && out_ready) begin
        if (report_queue.size() == 0) begin
          $display("%0t: result with none expected: start=%0d match=%0b done=%0b count=%0d ovf=%0b",
                   $time, out_start_index, out_is_match, out_done_res, out_match_count,
                   out_overflow);
          errs++;
        end else begin
          want = report_queue.pop_front();
          compare_field("start_index", want.start_index, out_start_index);
          compare_field("is_match", want.is_match, out_is_match);
          compare_field("done_res", want.done_res, out_done_res);
          compare_field("match_count", want.match_count, out_match_count);
          compare_field("overflow", want.overflow, out_overflow);
          if (want.done_res) texts_seen++;
          else hits_seen++;
        end
      end
      if (in_valid && in_ready) scan_element(in_cmd, in_value, in_last);
    end
    mismatches      <= errs;
    reports_due     <= report_queue.size();
    matches_checked <= hits_seen;
    texts_checked   <= texts_seen;
  end

endmodule

### verif/sequence_occurrence_finder_unit_tb.sv
`timescale 1ns / 1ps
module sequence_occurrence_finder_unit_tb;
  import sof_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 60_000;
  localparam int DRAIN_WAIT  = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_cmd = CMD_TEXT;
  logic [ELEM_BITS-1:0]  in_value = '0;
  logic                  in_last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [INDEX_BITS-1:0] out_start_index;
  logic                  out_is_match;
  logic                  out_done_res;
  logic [COUNT_BITS-1:0] out_match_count;
  logic                  out_overflow;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_first_only = 1'b0;

  int mismatches;
  int reports_due;
  int matches_checked;
  int texts_checked;
  int cycles = 0;
  int items_sent = 0;
  logic calm = 1'b0;

  // pattern as currently held by the block, tracked from the items sent
  logic [ELEM_BITS-1:0] tb_motif [MAX_PATTERN];
  int                   tb_motif_len = 0;
  logic [ELEM_BITS-1:0] sym_a = '0;
  logic [ELEM_BITS-1:0] sym_b = '0;

  sequence_occurrence_finder_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_start_index (out_start_index),
    .out_is_match    (out_is_match),
    .out_done_res    (out_done_res),
    .out_match_count (out_match_count),
    .out_overflow    (out_overflow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_first_only  (cfg_first_only)
  );

  sof_occurrence_checker occurrence_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_start_index (out_start_index),
    .out_is_match    (out_is_match),
    .out_done_res    (out_done_res),
    .out_match_count (out_match_count),
    .out_overflow    (out_overflow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_first_only  (cfg_first_only),
    .mismatches      (mismatches),
    .reports_due     (reports_due),
    .matches_checked (matches_checked),
    .texts_checked   (texts_checked)
  );

  always #2 clk = ~clk;

  // stall the result side at random unless calm
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 17);
  end

  // abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one item, hold it until accepted; returns at a falling edge
  task automatic send_item(logic [1:0] cmd, logic [ELEM_BITS-1:0] value, logic last);
    if (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 17) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= value;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd == CMD_LOAD) begin
      tb_motif[0]  = value;
      tb_motif_len = 1;
    end else if (cmd == CMD_APPEND && tb_motif_len < MAX_PATTERN) begin
      tb_motif[tb_motif_len] = value;
      tb_motif_len++;
    end
    if (cmd != CMD_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every report is in, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_first_only(logic mode);
    drain();
    cfg_valid      <= 1'b1;
    cfg_first_only <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load a fresh pattern over a two-symbol alphabet, sometimes past capacity
  task automatic load_motif();
    int n;
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) n = $urandom_range(4, 1);
    else if (pick < 85) n = $urandom_range(15, 5);
    else n = $urandom_range(MAX_PATTERN + 2, MAX_PATTERN);
    sym_a = ELEM_BITS'($urandom);
    sym_b = ($urandom_range(9) == 0) ? sym_a : ELEM_BITS'($urandom);
    for (int i = 0; i < n; i++) begin
      send_item(i == 0 ? CMD_LOAD : CMD_APPEND, $urandom_range(1) ? sym_a : sym_b,
                1'($urandom_range(1)));
    end
  endtask

  // One text: alphabet symbols with embedded pattern copies, some noise
  task automatic send_text();
    int n;
    int k;
    int pick;
    int span;
    logic [ELEM_BITS-1:0] v;
    n = $urandom_range(40, 1);
    k = 0;
    while (k < n) begin
      pick = $urandom_range(99);
      span = tb_motif_len;
      if (span > 0 && pick < 30 && k + span <= n) begin
        for (int j = 0; j < span; j++) send_item(CMD_TEXT, tb_motif[j], k + j == n - 1);
        k += span;
      end else if (pick < 33) begin
        // restart the text by editing the pattern
        send_item($urandom_range(1) ? CMD_LOAD : CMD_APPEND, ELEM_BITS'($urandom),
                  1'($urandom_range(1)));
      end else if (pick < 35) begin
        send_item(CMD_UNUSED, ELEM_BITS'($urandom), 1'($urandom_range(1)));
      end else begin
        if (pick < 42) v = ELEM_BITS'($urandom);
        else v = $urandom_range(1) ? sym_a : sym_b;
        send_item(CMD_TEXT, v, k == n - 1);
        k++;
      end
    end
  endtask

  task automatic run_texts(int quota);
    int goal;
    int pick;
    int burst;
    goal = items_sent + quota;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // noise: any command, any value
        burst = $urandom_range(6, 1);
        for (int i = 0; i < burst; i++) begin
          send_item(2'($urandom_range(3)), ELEM_BITS'($urandom), 1'($urandom_range(1)));
        end
      end else begin
        if (pick < 45) load_motif();
        send_text();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty pattern, unused command, last on pattern commands
    send_item(CMD_TEXT, 8'h00, 1'b0);
    send_item(CMD_TEXT, 8'hFF, 1'b1);
    send_item(CMD_UNUSED, 8'hA5, 1'b1);
    // overlapping matches at the value extremes
    send_item(CMD_LOAD, 8'hFF, 1'b1);
    send_item(CMD_APPEND, 8'hFF, 1'b0);
    send_item(CMD_TEXT, 8'hFF, 1'b0);
    send_item(CMD_TEXT, 8'hFF, 1'b0);
    send_item(CMD_TEXT, 8'hFF, 1'b0);
    send_item(CMD_TEXT, 8'h00, 1'b1);
    // pattern change in the middle of a text restarts it
    send_item(CMD_LOAD, 8'h00, 1'b0);
    send_item(CMD_APPEND, 8'h5A, 1'b1);
    send_item(CMD_TEXT, 8'h00, 1'b0);
    send_item(CMD_TEXT, 8'h5A, 1'b0);
    send_item(CMD_TEXT, 8'h5A, 1'b1);
    send_item(CMD_TEXT, 8'h00, 1'b0);
    send_item(CMD_APPEND, 8'h01, 1'b0);
    send_item(CMD_TEXT, 8'h00, 1'b0);
    send_item(CMD_TEXT, 8'h5A, 1'b0);
    send_item(CMD_TEXT, 8'h01, 1'b1);
    // first-only reporting still counts every match
    set_first_only(1'b1);
    send_item(CMD_LOAD, 8'h33, 1'b0);
    for (int i = 0; i < 4; i++) send_item(CMD_TEXT, 8'h33, i == 3);

    // random texts across both modes, with a calm stretch and a full drain
    set_first_only(1'b0);
    run_texts(380);
    drain();
    run_texts(190);
    set_first_only(1'b1);
    calm <= 1'b1;
    run_texts(330);
    calm <= 1'b0;
    set_first_only(1'b0);
    run_texts(230);
    set_first_only(1'b1);
    run_texts(230);

    drain();
    $display("Drove %0d items through random texts in both reporting modes, with idle gaps.",
             items_sent);
    $display("Checked %0d match and %0d end-of-text results, overlaps and restarts included.",
             matches_checked, texts_checked);
    if (mismatches == 0 && reports_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sof_pkg.sv
rtl/sof_core.sv
rtl/sof_outq.sv
rtl/sequence_occurrence_finder_unit.sv
rtl/sof_checker.sv
verif/sof_occurrence_checker.sv
verif/sequence_occurrence_finder_unit_tb.sv
